[hw/rtl/swsg_pkg.sv]
// shared types and constants for the sliding window stability gate
// no dependencies; imported by every module of the block
`default_nettype none

package swsg_pkg;

	// window storage
	localparam int MAX_WINDOW = 256;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int WIN_W      = ADDR_W + 1;

	// sample and sum widths
	localparam int SAMPLE_W = 16;
	localparam int SQ1_W    = 2 * SAMPLE_W - 1;
	localparam int SUM_W    = 24;
	localparam int SQ_W     = 39;

	// configuration widths
	localparam int ADV_W     = 16;
	localparam int LIM_W     = 15;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// advance counter saturates at 2^ADV_W
	localparam int SINCE_W = ADV_W + 1;

	// variance compare widths
	localparam int LHS_W  = WIN_W + SQ_W;
	localparam int MSQ_W  = 2 * SUM_W;
	localparam int L2_W   = 2 * LIM_W;
	localparam int NN_W   = 2 * WIN_W;
	localparam int PROD_W = L2_W + NN_W;
	localparam int CMP_MAX = (LHS_W > MSQ_W) ? ((LHS_W > PROD_W) ? LHS_W : PROD_W)
		: ((MSQ_W > PROD_W) ? MSQ_W : PROD_W);
	localparam int CMP_W  = CMP_MAX + 1;

	// register reset values
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(64);
	localparam logic [ADV_W-1:0] ADVANCE_RESET = ADV_W'(16);
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH,
		CFG_MIN_ADVANCE,
		CFG_GAIT_LIMIT,
		CFG_ANGVEL_LIMIT
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_UPDATE,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] gait;
		logic signed [SAMPLE_W-1:0] angvel;
	} ring_word_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic take;
		logic square;
		logic update;
	} win_ctrl_t;

	typedef struct packed {
		logic [WIN_W-1:0]        fill;
		logic signed [SUM_W-1:0] gait_acc;
		logic signed [SUM_W-1:0] angvel_acc;
		logic [SQ_W-1:0]         gait_sq_acc;
		logic [SQ_W-1:0]         angvel_sq_acc;
		logic                    counts_ok;
	} win_stat_t;

	typedef struct packed {
		logic stage1;
		logic stage2;
	} var_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/swsg_ring_ram.sv]
// sample ring storage: one write port, one read port, registered read data
// depends on swsg_pkg
`default_nettype none

module swsg_ring_ram import swsg_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  ring_word_t        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output ring_word_t        rd_data
);

	ring_word_t mem [MAX_WINDOW];
	ring_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hw/rtl/swsg_window.sv]
// window bookkeeping: ring pointer, fill and advance counters, running sums
// depends on swsg_pkg; reads and writes the ring through swsg_ring_ram
`default_nettype none

module swsg_window import swsg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  win_ctrl_t                  ctrl,
	input  logic [WIN_W-1:0]           n,
	input  logic [ADV_W-1:0]           min_adv,
	input  logic signed [SAMPLE_W-1:0] gait_in,
	input  logic signed [SAMPLE_W-1:0] angvel_in,
	input  ring_word_t                 old_word,
	output logic [ADDR_W-1:0]          rd_addr,
	output logic [ADDR_W-1:0]          wr_addr,
	output ring_word_t                 wr_data,
	output win_stat_t                  stat
);

	logic [ADDR_W-1:0]          head_q;
	logic [ADDR_W-1:0]          slot_q;
	logic [WIN_W-1:0]           fill_q;
	logic [WIN_W-1:0]           total_q;
	logic [SINCE_W-1:0]         since_q;
	logic signed [SUM_W-1:0]    gait_acc_q;
	logic signed [SUM_W-1:0]    angvel_acc_q;
	logic [SQ_W-1:0]            gait_sq_q;
	logic [SQ_W-1:0]            angvel_sq_q;
	logic signed [SAMPLE_W-1:0] gait_new_q;
	logic signed [SAMPLE_W-1:0] angvel_new_q;

	logic signed [SAMPLE_W-1:0] gait_old_s1;
	logic signed [SAMPLE_W-1:0] angvel_old_s1;
	logic [SQ1_W-1:0]           gait_new_sq_s1;
	logic [SQ1_W-1:0]           angvel_new_sq_s1;
	logic [SQ1_W-1:0]           gait_old_sq_s1;
	logic [SQ1_W-1:0]           angvel_old_sq_s1;

	logic [ADDR_W-1:0] slot;
	logic [WIN_W-1:0]  slot_inc;
	logic [ADDR_W-1:0] head_next;
	logic              full;
	logic              total_sat;
	logic              since_sat;

	function automatic logic [SQ1_W-1:0] sample_sq(input logic signed [SAMPLE_W-1:0] x);
		logic signed [2*SAMPLE_W-1:0] p;
		p = x * x;
		return p[SQ1_W-1:0];
	endfunction

	// current write slot, clamped into the window
	assign slot      = ({1'b0, head_q} >= n) ? '0 : head_q;
	assign slot_inc  = {1'b0, slot_q} + WIN_W'(1);
	assign head_next = (slot_inc >= n) ? '0 : slot_inc[ADDR_W-1:0];
	assign full      = (fill_q >= n);
	assign total_sat = ({1'b0, total_q} >= ({1'b0, n} + (WIN_W + 1)'(1)));
	assign since_sat = since_q[SINCE_W-1];

	assign rd_addr = slot;
	assign wr_addr = slot_q;
	assign wr_data = '{gait: gait_new_q, angvel: angvel_new_q};

	// incoming samples and their slot
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			gait_new_q   <= gait_in;
			angvel_new_q <= angvel_in;
			slot_q       <= slot;
		end
	end

	// squares of the new and evicted samples
	always_ff @(posedge clk) begin
		if (ctrl.square) begin
			gait_old_s1      <= old_word.gait;
			angvel_old_s1    <= old_word.angvel;
			gait_new_sq_s1   <= sample_sq(gait_new_q);
			angvel_new_sq_s1 <= sample_sq(angvel_new_q);
			gait_old_sq_s1   <= sample_sq(old_word.gait);
			angvel_old_sq_s1 <= sample_sq(old_word.angvel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			fill_q       <= '0;
			total_q      <= '0;
			since_q      <= '0;
			gait_acc_q   <= '0;
			angvel_acc_q <= '0;
			gait_sq_q    <= '0;
			angvel_sq_q  <= '0;
		end else if (ctrl.clear) begin
			head_q       <= '0;
			fill_q       <= '0;
			total_q      <= '0;
			gait_acc_q   <= '0;
			angvel_acc_q <= '0;
			gait_sq_q    <= '0;
			angvel_sq_q  <= '0;
		end else if (ctrl.take) begin
			since_q <= '0;
		end else if (ctrl.update) begin
			head_q <= head_next;
			if (full) begin
				gait_acc_q   <= gait_acc_q + SUM_W'(gait_new_q) - SUM_W'(gait_old_s1);
				angvel_acc_q <= angvel_acc_q + SUM_W'(angvel_new_q) - SUM_W'(angvel_old_s1);
				gait_sq_q    <= gait_sq_q + SQ_W'(gait_new_sq_s1) - SQ_W'(gait_old_sq_s1);
				angvel_sq_q  <= angvel_sq_q + SQ_W'(angvel_new_sq_s1)
					- SQ_W'(angvel_old_sq_s1);
			end else begin
				fill_q       <= fill_q + WIN_W'(1);
				gait_acc_q   <= gait_acc_q + SUM_W'(gait_new_q);
				angvel_acc_q <= angvel_acc_q + SUM_W'(angvel_new_q);
				gait_sq_q    <= gait_sq_q + SQ_W'(gait_new_sq_s1);
				angvel_sq_q  <= angvel_sq_q + SQ_W'(angvel_new_sq_s1);
			end
			if (!total_sat) begin
				total_q <= total_q + WIN_W'(1);
			end
			if (!since_sat) begin
				since_q <= since_q + SINCE_W'(1);
			end
		end
	end

	assign stat = '{
		fill:          fill_q,
		gait_acc:      gait_acc_q,
		angvel_acc:    angvel_acc_q,
		gait_sq_acc:   gait_sq_q,
		angvel_sq_acc: angvel_sq_q,
		counts_ok:     (total_q > n) && (since_q > SINCE_W'(min_adv))
	};

`ifndef SYNTHESIS
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= n) else $error("fill count above window length");

	a_head_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < n) else $error("ring head outside window");

	a_fill_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= total_q) else $error("fill count above total count");

	a_take_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take && !ctrl.clear |=> since_q == '0) else $error("take did not restart count");
`endif

endmodule

`default_nettype wire

[hw/rtl/swsg_var_check.sv]
// cross-multiplied variance test: n*ss <= l*l*n*(n-1) + s*s, two multiply stages
// depends on swsg_pkg
`default_nettype none

module swsg_var_check import swsg_pkg::*; (
	input  logic                    clk,
	input  var_ctrl_t               ctrl,
	input  logic [WIN_W-1:0]        n,
	input  logic signed [SUM_W-1:0] sum,
	input  logic [SQ_W-1:0]         sq_sum,
	input  logic [LIM_W-1:0]        limit,
	output logic                    stable
);

	logic [SUM_W-1:0]  sum_bits;
	logic [SUM_W-1:0]  mag;
	logic [WIN_W-1:0]  n_dec;

	logic [LHS_W-1:0]  lhs_s1;
	logic [MSQ_W-1:0]  msq_s1;
	logic [L2_W-1:0]   l2_s1;
	logic [NN_W-1:0]   nn_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [CMP_W-1:0]  rhs;

	assign sum_bits = sum;
	assign mag      = sum_bits[SUM_W-1] ? (~sum_bits + SUM_W'(1)) : sum_bits;
	assign n_dec    = n - WIN_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.stage1) begin
			lhs_s1 <= LHS_W'(n) * LHS_W'(sq_sum);
			msq_s1 <= MSQ_W'(mag) * MSQ_W'(mag);
			l2_s1  <= L2_W'(limit) * L2_W'(limit);
			nn_s1  <= NN_W'(n) * NN_W'(n_dec);
		end
		if (ctrl.stage2) begin
			prod_s2 <= PROD_W'(l2_s1) * PROD_W'(nn_s1);
		end
	end

	assign rhs    = CMP_W'(prod_s2) + CMP_W'(msq_s1);
	assign stable = (CMP_W'(lhs_s1) <= rhs);

endmodule

`default_nettype wire

[hw/rtl/sliding_window_stability_gate_unit.sv]
// top level of the sliding window stability gate: control sequencer,
// configuration registers, result register; uses swsg_pkg, swsg_ring_ram,
// swsg_window and swsg_var_check
`default_nettype none

// Keeps the last N gait and angular-velocity samples (N = window_length,
// clamped to 2..256) in a ring memory, with exact running sums and sums of
// squares, and answers every input item with one result: the fill count,
// the four sums and a ready flag. Ready is high when more than N samples have
// been added since the last window_length write, more than min_advance since
// the last take command, and both window variances are at or below the square
// of their std limits (tested as n*ss <= l*l*n*(n-1) + s*s, no division).
// An add item passes from transfer to result through one ring read, one square
// step, one sum update, two multiply stages and the compare; a take item skips
// the ring access and the sum update. Items are handled one at a time;
// the next item can transfer while a finished result still waits on a stalled
// output. Writing window_length empties the window; configuration is meant to
// be written only when no item is in flight. The ring needs no clearing after
// reset: only entries already written are ever used in the sums.

module sliding_window_stability_gate_unit import swsg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,

	// configuration write port
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,

	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic signed [SAMPLE_W-1:0] gait_sample,
	input  logic signed [SAMPLE_W-1:0] angvel_sample,

	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       ready_res,
	output logic [WIN_W-1:0]           window_fill,
	output logic signed [SUM_W-1:0]    gait_sum,
	output logic signed [SUM_W-1:0]    angvel_sum,
	output logic [SQ_W-1:0]            gait_square_sum,
	output logic [SQ_W-1:0]            angvel_square_sum
);

	// configuration
	logic [WIN_W-1:0] win_len_q;
	logic [ADV_W-1:0] min_adv_q;
	logic [LIM_W-1:0] gait_lim_q;
	logic [LIM_W-1:0] angvel_lim_q;
	logic [WIN_W-1:0] cfg_len;
	logic [WIN_W-1:0] cfg_len_clamped;

	// sequencer
	state_t    state_q;
	state_t    state_next;
	logic      in_xfer;
	logic      out_load;
	win_ctrl_t win_ctrl;
	var_ctrl_t var_ctrl;

	// datapath links
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	ring_word_t        wr_data;
	ring_word_t        rd_data;
	win_stat_t         stat;
	logic              gait_stable;
	logic              angvel_stable;

	// result register
	logic                    out_valid_q;
	logic                    ready_q;
	logic [WIN_W-1:0]        fill_q;
	logic signed [SUM_W-1:0] gait_sum_q;
	logic signed [SUM_W-1:0] angvel_sum_q;
	logic [SQ_W-1:0]         gait_sq_q;
	logic [SQ_W-1:0]         angvel_sq_q;

	// ------------------------------------------------------------------
	// configuration registers; window length is stored already clamped
	// ------------------------------------------------------------------
	assign cfg_len = cfg_data[WIN_W-1:0];
	assign cfg_len_clamped = (cfg_len < WIN_W'(2)) ? WIN_W'(2)
		: (cfg_len > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : cfg_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q    <= WINDOW_RESET;
			min_adv_q    <= ADVANCE_RESET;
			gait_lim_q   <= LIMIT_RESET;
			angvel_lim_q <= LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_WINDOW_LENGTH: win_len_q    <= cfg_len_clamped;
				CFG_MIN_ADVANCE:   min_adv_q    <= cfg_data[ADV_W-1:0];
				CFG_GAIT_LIMIT:    gait_lim_q   <= cfg_data[LIM_W-1:0];
				CFG_ANGVEL_LIMIT:  angvel_lim_q <= cfg_data[LIM_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sequencer: one item at a time
	// ------------------------------------------------------------------
	assign in_xfer = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					// take skips the ring and the sum update
					state_next = command ? ST_MUL1 : ST_SQUARE;
				end
			end
			ST_SQUARE: state_next = ST_UPDATE;
			ST_UPDATE: state_next = ST_MUL1;
			ST_MUL1:   state_next = ST_MUL2;
			ST_MUL2:   state_next = ST_DONE;
			ST_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || !out_stall) begin
					state_next = ST_IDLE;
				end
			end
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall        = (state_q != ST_IDLE);
		win_ctrl.clear  = cfg_write && (cfg_index_t'(cfg_index) == CFG_WINDOW_LENGTH);
		win_ctrl.load   = in_xfer && !command;
		win_ctrl.take   = in_xfer && command;
		win_ctrl.square = (state_q == ST_SQUARE);
		win_ctrl.update = (state_q == ST_UPDATE);
		var_ctrl.stage1 = (state_q == ST_MUL1);
		var_ctrl.stage2 = (state_q == ST_MUL2);
		out_load        = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	// ring read issued on the add transfer, write back during the square step
	swsg_ring_ram u_ring (
		.clk     (clk),
		.wr_en   (win_ctrl.square),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (win_ctrl.load),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	swsg_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.n         (win_len_q),
		.min_adv   (min_adv_q),
		.gait_in   (gait_sample),
		.angvel_in (angvel_sample),
		.old_word  (rd_data),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.stat      (stat)
	);

	swsg_var_check u_gait_var (
		.clk    (clk),
		.ctrl   (var_ctrl),
		.n      (win_len_q),
		.sum    (stat.gait_acc),
		.sq_sum (stat.gait_sq_acc),
		.limit  (gait_lim_q),
		.stable (gait_stable)
	);

	swsg_var_check u_angvel_var (
		.clk    (clk),
		.ctrl   (var_ctrl),
		.n      (win_len_q),
		.sum    (stat.angvel_acc),
		.sq_sum (stat.angvel_sq_acc),
		.limit  (angvel_lim_q),
		.stable (angvel_stable)
	);

	// ------------------------------------------------------------------
	// result register: holds while stalled, frees on transfer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ready_q      <= stat.counts_ok && gait_stable && angvel_stable;
			fill_q       <= stat.fill;
			gait_sum_q   <= stat.gait_acc;
			angvel_sum_q <= stat.angvel_acc;
			gait_sq_q    <= stat.gait_sq_acc;
			angvel_sq_q  <= stat.angvel_sq_acc;
		end
	end

	assign out_valid         = out_valid_q;
	assign ready_res         = ready_q;
	assign window_fill       = fill_q;
	assign gait_sum          = gait_sum_q;
	assign angvel_sum        = angvel_sum_q;
	assign gait_square_sum   = gait_sq_q;
	assign angvel_square_sum = angvel_sq_q;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for the sliding window stability gate: predicts every result
// of sliding_window_stability_gate_unit and compares field by field; uses swsg_pkg

module testbench;
	import swsg_pkg::*;

	// item commands
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	// advance count saturates here
	localparam int unsigned SINCE_CAP = 65536;

	// run control: about 2k items plus stalls, drains and writes
	localparam int CYCLE_LIMIT   = 200_000;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int FLAT_OUT      = 150;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_AFTER    = 100;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] gait;
		logic [SAMPLE_W-1:0] angvel;
	} sample_item_t;

	typedef struct packed {
		logic                    ready;
		logic [WIN_W-1:0]        fill;
		logic signed [SUM_W-1:0] gait_sum;
		logic signed [SUM_W-1:0] angvel_sum;
		logic [SQ_W-1:0]         gait_sq;
		logic [SQ_W-1:0]         angvel_sq;
	} window_report_t;

	// block ports, all inputs known from time zero
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       command = CMD_ADD;
	logic signed [SAMPLE_W-1:0] gait_sample = '0;
	logic signed [SAMPLE_W-1:0] angvel_sample = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       ready_res;
	logic [WIN_W-1:0]           window_fill;
	logic signed [SUM_W-1:0]    gait_sum;
	logic signed [SUM_W-1:0]    angvel_sum;
	logic [SQ_W-1:0]            gait_square_sum;
	logic [SQ_W-1:0]            angvel_square_sum;

	sliding_window_stability_gate_unit dut (.*);

	// predictor copy of the configuration, reset values as after reset
	logic [WIN_W-1:0] win_len_reg    = WINDOW_RESET;
	logic [ADV_W-1:0] min_adv_reg    = ADVANCE_RESET;
	logic [LIM_W-1:0] gait_lim_reg   = LIMIT_RESET;
	logic [LIM_W-1:0] angvel_lim_reg = LIMIT_RESET;

	// predictor copy of the window
	logic [SAMPLE_W-1:0] gait_hist [MAX_WINDOW];
	logic [SAMPLE_W-1:0] angvel_hist [MAX_WINDOW];
	int unsigned         ring_slot = 0;
	int unsigned         held = 0;
	int unsigned         seen_total = 0;
	int unsigned         adds_since_take = 0;
	longint              gait_total = 0;
	longint              angvel_total = 0;
	longint unsigned     gait_sq_total = 0;
	longint unsigned     angvel_sq_total = 0;

	// items waiting for the driver, results waiting for the block
	sample_item_t   item_queue[$];
	window_report_t report_queue[$];
	sample_item_t   staged_item;
	window_report_t next_report;

	int gap_pct = 23;
	int error_count = 0;
	int queued = 0;
	int results_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// effective window length, clamped to the legal range
	function automatic int unsigned active_len();
		if (win_len_reg < 2)
			return 2;
		if (win_len_reg > MAX_WINDOW)
			return MAX_WINDOW;
		return win_len_reg;
	endfunction

	function automatic longint unsigned square(longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	// n*ss <= l*l*n*(n-1) + s*s, exact in 64 bits for these widths
	function automatic bit within_limit(int unsigned n, longint s, longint unsigned ss,
			logic [LIM_W-1:0] lim);
		longint unsigned lhs;
		longint unsigned mag;
		longint unsigned l2;
		longint unsigned rhs;
		lhs = 64'(n) * ss;
		mag = (s < 0) ? -s : s;
		l2  = 64'(lim) * 64'(lim);
		rhs = l2 * 64'(n) * 64'(n - 1) + mag * mag;
		return lhs <= rhs;
	endfunction

	// window length writes and reset empty the window; advance count survives
	function automatic void empty_window();
		ring_slot       = 0;
		held            = 0;
		seen_total      = 0;
		gait_total      = 0;
		angvel_total    = 0;
		gait_sq_total   = 0;
		angvel_sq_total = 0;
	endfunction

	// apply one accepted item to the window copy and build its expected result
	function automatic window_report_t absorb_item(logic cmd, logic [SAMPLE_W-1:0] g,
			logic [SAMPLE_W-1:0] a);
		int unsigned    n;
		int unsigned    slot;
		longint         old_g;
		longint         old_a;
		window_report_t rep;
		n = active_len();
		if (cmd == CMD_TAKE) begin
			// samples ignored, window unchanged
			adds_since_take = 0;
		end else begin
			slot = ring_slot;
			if (slot >= n)
				slot = 0;
			if (held >= n) begin
				// full window: the oldest sample drops out
				old_g = longint'($signed(gait_hist[slot]));
				old_a = longint'($signed(angvel_hist[slot]));
				gait_total      -= old_g;
				angvel_total    -= old_a;
				gait_sq_total   -= square(old_g);
				angvel_sq_total -= square(old_a);
			end else begin
				held++;
			end
			gait_hist[slot]   = g;
			angvel_hist[slot] = a;
			gait_total      += longint'($signed(g));
			angvel_total    += longint'($signed(a));
			gait_sq_total   += square(longint'($signed(g)));
			angvel_sq_total += square(longint'($signed(a)));
			ring_slot = (slot + 1 >= n) ? 0 : slot + 1;
			if (seen_total < n + 1)
				seen_total++;
			if (adds_since_take < SINCE_CAP)
				adds_since_take++;
		end
		rep.ready = seen_total > n && adds_since_take > min_adv_reg
			&& within_limit(n, gait_total, gait_sq_total, gait_lim_reg)
			&& within_limit(n, angvel_total, angvel_sq_total, angvel_lim_reg);
		rep.fill       = WIN_W'(held);
		rep.gait_sum   = SUM_W'(gait_total);
		rep.angvel_sum = SUM_W'(angvel_total);
		rep.gait_sq    = SQ_W'(gait_sq_total);
		rep.angvel_sq  = SQ_W'(angvel_sq_total);
		return rep;
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want_v,
			logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			error_count++;
		end
	endfunction

	function automatic void add_item(logic cmd, logic [SAMPLE_W-1:0] g,
			logic [SAMPLE_W-1:0] a);
		sample_item_t it;
		it = '{cmd, g, a};
		item_queue.insert(item_queue.size(), it);
		queued++;
	endfunction

	// noise width for one phase, from steady to wild
	function automatic int pick_spread();
		case ($urandom_range(4))
			0: return 0;
			1: return 8;
			2: return 200;
			3: return 3000;
			default: return 20000;
		endcase
	endfunction

	// std limit near the phase's noise so that ready flips both ways; bit 15 is dropped
	function automatic logic [CFG_W-1:0] pick_limit(int spread);
		int lim;
		case ($urandom_range(5))
			0: lim = 0;
			1: lim = 32767;
			default: lim = spread / 2 + int'($urandom_range(spread));
		endcase
		if (lim > 32767)
			lim = 32767;
		return {1'($urandom_range(1)), 15'(lim)};
	endfunction

	// mostly center plus noise, with some full-range and full-scale samples
	function automatic logic [SAMPLE_W-1:0] make_sample(int center, int spread);
		int v;
		case ($urandom_range(19))
			0: return SAMPLE_W'($urandom);
			1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: begin
				v = center + int'($urandom_range(2 * spread)) - spread;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				return SAMPLE_W'(v);
			end
		endcase
	endfunction

	// register write at one clock edge; the block is idle, so the copy follows at once
	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_WINDOW_LENGTH: begin
				win_len_reg = value[WIN_W-1:0];
				empty_window();
			end
			CFG_MIN_ADVANCE:  min_adv_reg    = value[ADV_W-1:0];
			CFG_GAIT_LIMIT:   gait_lim_reg   = value[LIM_W-1:0];
			CFG_ANGVEL_LIMIT: angvel_lim_reg = value[LIM_W-1:0];
			default: ;
		endcase
	endtask

	// wait until every item is through and every result is back, then let the block settle
	task automatic drain();
		do
			@(negedge clk);
		while (item_queue.size() != 0 || in_valid || report_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// driver: predicts at each input transfer, then offers the next item or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			command       <= CMD_ADD;
			gait_sample   <= '0;
			angvel_sample <= '0;
		end else begin
			if (in_valid && !in_stall)
				report_queue.insert(report_queue.size(),
					absorb_item(command, gait_sample, angvel_sample));
			// a stalled item keeps its payload
			if (!in_valid || !in_stall) begin
				if (item_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
					staged_item = item_queue[0];
					item_queue.delete(0);
					in_valid      <= 1'b1;
					command       <= staged_item.cmd;
					gait_sample   <= staged_item.gait;
					angvel_sample <= staged_item.angvel;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (report_queue.size() == 0) begin
					$error("result transfer with no expected result waiting");
					error_count++;
				end else begin
					next_report = report_queue[0];
					report_queue.delete(0);
					check_field("ready_res", 64'(next_report.ready), 64'(ready_res));
					check_field("window_fill", 64'(next_report.fill), 64'(window_fill));
					check_field("gait_sum", 64'(next_report.gait_sum), 64'(gait_sum));
					check_field("angvel_sum", 64'(next_report.angvel_sum), 64'(angvel_sum));
					check_field("gait_square_sum", 64'(next_report.gait_sq),
						64'(gait_square_sum));
					check_field("angvel_square_sum", 64'(next_report.angvel_sq),
						64'(angvel_square_sum));
				end
				results_seen++;
				// one long hold-off so the block backs up into its input
				if (results_seen == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < gap_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		bit                first;
		int                count;
		int                gait_center;
		int                angvel_center;
		int                gait_spread;
		int                angvel_spread;
		logic [WIN_W-1:0]  len;
		logic [ADV_W-1:0]  adv;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration in use before any write
		add_item(CMD_ADD, 16'h0100, 16'hFF00);
		add_item(CMD_TAKE, 16'h8000, 16'h7FFF);
		drain();

		// shortest window (length 1 clamps to 2, upper data bits dropped), loosest limits
		write_reg(CFG_WINDOW_LENGTH, 16'hFE01);
		write_reg(CFG_MIN_ADVANCE, 16'h0000);
		write_reg(CFG_GAIT_LIMIT, 16'hFFFF);
		write_reg(CFG_ANGVEL_LIMIT, 16'h7FFF);
		add_item(CMD_TAKE, 16'hFFFF, 16'hFFFF);  // take on an empty window
		add_item(CMD_ADD, 16'h8000, 16'h7FFF);
		add_item(CMD_ADD, 16'h7FFF, 16'h8000);
		add_item(CMD_ADD, 16'h8000, 16'h8000);   // full-scale swing, too wide even so
		add_item(CMD_ADD, 16'h8000, 16'h8000);   // flat window at negative full scale
		add_item(CMD_ADD, 16'h0000, 16'h0000);
		add_item(CMD_ADD, 16'h0000, 16'h0000);
		add_item(CMD_TAKE, 16'h1234, 16'h5678);  // samples of a take are ignored
		add_item(CMD_ADD, 16'hFFFF, 16'h0001);
		add_item(CMD_ADD, 16'h0001, 16'hFFFF);
		add_item(CMD_ADD, 16'h7FFF, 16'h7FFF);
		add_item(CMD_ADD, 16'h7FFF, 16'h7FFF);
		drain();

		// zero limit: only a flat window passes
		write_reg(CFG_GAIT_LIMIT, 16'h0000);
		write_reg(CFG_ANGVEL_LIMIT, 16'h0000);
		add_item(CMD_ADD, 16'h0005, 16'h0005);
		add_item(CMD_ADD, 16'h0005, 16'h0005);
		add_item(CMD_ADD, 16'h0005, 16'h0006);
		drain();

		// variance exactly at the limit: window of three, samples -1 0 1, limit 1
		write_reg(CFG_WINDOW_LENGTH, 16'h0003);
		write_reg(CFG_GAIT_LIMIT, 16'h0001);
		write_reg(CFG_ANGVEL_LIMIT, 16'h0001);
		add_item(CMD_ADD, 16'hFFFF, 16'hFFFF);
		add_item(CMD_ADD, 16'h0000, 16'h0000);
		add_item(CMD_ADD, 16'h0001, 16'h0001);
		add_item(CMD_ADD, 16'hFFFF, 16'hFFFF);
		add_item(CMD_ADD, 16'h0002, 16'h0002);
		drain();

		// random phases: new settings between phases, noisy steady data within
		first = 1'b1;
		while (queued < RANDOM_ITEMS) begin
			gait_center   = int'($urandom_range(65535)) - 32768;
			angvel_center = int'($urandom_range(65535)) - 32768;
			gait_spread   = pick_spread();
			angvel_spread = pick_spread();
			if (first || $urandom_range(9) < 6) begin
				case ($urandom_range(9))
					0: len = WIN_W'($urandom_range(1));
					1: len = WIN_W'(MAX_WINDOW);
					2: len = WIN_W'($urandom_range(511, MAX_WINDOW + 1));
					default: len = WIN_W'($urandom_range(24, 2));
				endcase
				write_reg(CFG_WINDOW_LENGTH, {7'($urandom), len});
				count = active_len() + $urandom_range(120, 20);
			end else begin
				count = $urandom_range(160, 40);
			end
			// first phase is long enough to hold the output hold-off
			if (first)
				count = 250;
			if (first || $urandom_range(1)) begin
				case ($urandom_range(7))
					0: adv = '0;
					1: adv = '1;
					2: adv = ADV_W'($urandom);
					default: adv = ADV_W'($urandom_range(40));
				endcase
				write_reg(CFG_MIN_ADVANCE, adv);
			end
			if (first || $urandom_range(2) != 0)
				write_reg(CFG_GAIT_LIMIT, pick_limit(gait_spread));
			if (first || $urandom_range(2) != 0)
				write_reg(CFG_ANGVEL_LIMIT, pick_limit(angvel_spread));
			repeat (count) begin
				if ($urandom_range(24) == 0)
					add_item(CMD_TAKE, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
				else
					add_item(CMD_ADD, make_sample(gait_center, gait_spread),
						make_sample(angvel_center, angvel_spread));
			end
			drain();
			first = 1'b0;
		end

		// largest min_advance: ready stays low with a stable window;
		// both sides run without gaps for the whole stretch
		gap_pct = 0;
		write_reg(CFG_WINDOW_LENGTH, 16'h0000);
		write_reg(CFG_MIN_ADVANCE, 16'hFFFF);
		write_reg(CFG_GAIT_LIMIT, 16'h7FFF);
		write_reg(CFG_ANGVEL_LIMIT, 16'h7FFF);
		add_item(CMD_TAKE, 16'h0000, 16'h0000);
		repeat (FLAT_OUT)
			add_item(CMD_ADD, SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)));
		add_item(CMD_TAKE, 16'h0000, 16'h0000);
		repeat (5)
			add_item(CMD_ADD, SAMPLE_W'($urandom_range(255)), SAMPLE_W'($urandom_range(255)));
		drain();

		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
